>>> src/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
// Holds the mapper kind and target codes, the bank state and result structs.
// No dependencies.
`default_nettype none

package cbm_pkg;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_MBC1 = 3'd1,
        KIND_MBC2 = 3'd2,
        KIND_MBC3 = 3'd3,
        KIND_MBC5 = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        TGT_NOT_CART  = 3'd0,
        TGT_ROM_READ  = 3'd1,
        TGT_RAM_READ  = 3'd2,
        TGT_RAM_WRITE = 3'd3,
        TGT_OPEN_BUS  = 3'd4,
        TGT_REG_WRITE = 3'd5,
        TGT_IGN_WRITE = 3'd6
    } target_t;

    localparam int unsigned AddrW  = 16;
    localparam int unsigned DataW  = 8;
    localparam int unsigned PhysW  = 23;
    localparam int unsigned RomBkW = 9;
    localparam int unsigned RamBkW = 4;

    localparam logic [3:0]       RamGateNibble = 4'hA;
    localparam logic [DataW-1:0] RamGateByte   = 8'h0A;
    localparam logic [DataW-1:0] OpenBusByte   = 8'hFF;
    localparam logic [2:0]       RamWinTop     = 3'b101;

    typedef struct packed {
        logic              ram_enable;
        logic [RomBkW-1:0] rom_bank;
        logic [RamBkW-1:0] ram_bank;
        logic              banking_mode;
    } bank_state_t;

    typedef struct packed {
        target_t          target;
        logic [PhysW-1:0] physical_address;
        logic [DataW-1:0] data_out;
    } result_t;

endpackage

`default_nettype wire

>>> src/cbm_decode.sv
// Combinational classification of one bus access and the next bank state.
// Depends on cbm_pkg for the kind and target codes and the state and result structs.
`default_nettype none

module cbm_decode
    import cbm_pkg::*;
(
    input  wire logic [2:0]       mapper_kind,
    input  wire bank_state_t      state,
    input  wire logic             mode,
    input  wire logic [AddrW-1:0] address,
    input  wire logic [DataW-1:0] write_data,
    output bank_state_t           state_next,
    output result_t               result
);

    kind_t             kind;
    logic [RomBkW-1:0] bank;
    logic [RamBkW-1:0] ram_sel;
    logic [3:0]        low_bank4;
    logic [4:0]        low_bank5;

    always_comb
    begin
        case (mapper_kind)
            KIND_MBC1: kind = KIND_MBC1;
            KIND_MBC2: kind = KIND_MBC2;
            KIND_MBC3: kind = KIND_MBC3;
            KIND_MBC5: kind = KIND_MBC5;
            default:   kind = KIND_NONE;
        endcase
    end

    always_comb
    begin
        low_bank5 = (write_data[4:0] == 5'd0) ? 5'd1 : write_data[4:0];
        low_bank4 = (write_data[3:0] == 4'd0) ? 4'd1 : write_data[3:0];

        if (!address[14]) begin
            bank = (kind == KIND_MBC1 && state.banking_mode)
                 ? {2'b00, state.ram_bank[1:0], 5'd0} : '0;
        end else if (kind == KIND_NONE) begin
            bank = RomBkW'(1);
        end else if (kind == KIND_MBC1) begin
            bank = {2'b00, state.ram_bank[1:0], state.rom_bank[4:0]};
        end else begin
            bank = state.rom_bank;
        end

        if (kind == KIND_MBC1) begin
            ram_sel = state.banking_mode ? {2'b00, state.ram_bank[1:0]} : '0;
        end else begin
            ram_sel = state.ram_bank;
        end
    end

    always_comb
    begin
        state_next = state;
        result.target = TGT_NOT_CART;
        result.physical_address = '0;
        result.data_out = '0;

        if (!address[15]) begin
            if (mode) begin
                result.target = TGT_REG_WRITE;
                case (kind)
                    KIND_MBC1:
                    begin
                        case (address[14:13])
                            2'd0: state_next.ram_enable = (write_data[3:0] == RamGateNibble);
                            2'd1: state_next.rom_bank = {4'd0, low_bank5};
                            2'd2: state_next.ram_bank = {2'b00, write_data[1:0]};
                            default: state_next.banking_mode = write_data[0];
                        endcase
                    end
                    KIND_MBC2:
                    begin
                        if (address[14]) begin
                            result.target = TGT_IGN_WRITE;
                        end else if (!address[8]) begin
                            state_next.ram_enable = (write_data[3:0] == RamGateNibble);
                        end else begin
                            state_next.rom_bank = {5'd0, low_bank4};
                        end
                    end
                    KIND_MBC3:
                    begin
                        case (address[14:13])
                            2'd0: state_next.ram_enable = (write_data[3:0] == RamGateNibble);
                            2'd1: state_next.rom_bank = (write_data == '0)
                                ? RomBkW'(1) : {1'b0, write_data};
                            2'd2: state_next.ram_bank = write_data[3:0];
                            default: result.target = TGT_IGN_WRITE;
                        endcase
                    end
                    KIND_MBC5:
                    begin
                        case (address[14:12])
                            3'd0, 3'd1: state_next.ram_enable = (write_data == RamGateByte);
                            3'd2: state_next.rom_bank[7:0] = write_data;
                            3'd3: state_next.rom_bank[8] = write_data[0];
                            3'd4, 3'd5: state_next.ram_bank = write_data[3:0];
                            default: result.target = TGT_IGN_WRITE;
                        endcase
                    end
                    default: result.target = TGT_IGN_WRITE;
                endcase
            end else begin
                result.target = TGT_ROM_READ;
                result.physical_address = {bank, address[13:0]};
            end
        end else if (address[15:13] == RamWinTop) begin
            if (kind == KIND_NONE || !state.ram_enable) begin
                if (mode) begin
                    result.target = TGT_IGN_WRITE;
                end else begin
                    result.target = TGT_OPEN_BUS;
                    result.data_out = OpenBusByte;
                end
            end else begin
                if (kind == KIND_MBC2) begin
                    result.physical_address = {14'd0, address[8:0]};
                end else begin
                    result.physical_address = {6'd0, ram_sel, address[12:0]};
                end
                if (mode) begin
                    result.target = TGT_RAM_WRITE;
                    result.data_out = (kind == KIND_MBC2)
                        ? {4'd0, write_data[3:0]} : write_data;
                end else begin
                    result.target = TGT_RAM_READ;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> src/cbm_result_buf.sv
// Two-entry result buffer: an output register with a skid register behind it.
// Depends on cbm_pkg for the result struct.
`default_nettype none

module cbm_result_buf
    import cbm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         rsp_valid,
    input  wire logic    rsp_stall,
    output result_t      rsp_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    main_free;

    assign main_free = !main_valid_reg || !rsp_stall;
    assign full      = skid_valid_reg;
    assign rsp_valid = main_valid_reg;
    assign rsp_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free) begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> src/cartridge_bank_mapper.sv
// Cartridge memory bank controller: classifies each bus access and tracks bank registers.
// One access per cycle is taken while req_stall is low. An accepted access is registered
// in the output register, or in the skid register while a result waits there.
// Reset clears the mapper kind to plain ROM, gates RAM off, sets ROM bank 1 and RAM bank 0.
// Depends on cbm_pkg, cbm_decode and cbm_result_buf.
`default_nettype none

module cartridge_bank_mapper
    import cbm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [2:0]       cfg_wr_data,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire logic             mode,
    input  wire logic [AddrW-1:0] address,
    input  wire logic [DataW-1:0] write_data,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output logic [2:0]            target,
    output logic [PhysW-1:0]      physical_address,
    output logic [DataW-1:0]      data_out
);

    logic [2:0]  mapper_kind_reg;
    bank_state_t state_reg;
    bank_state_t state_next;
    result_t     result;
    result_t     rsp_data;
    logic        buf_full;
    logic        accept;

    assign req_stall = buf_full;
    assign accept    = req_valid && !buf_full;

    cbm_decode u_decode (
        .mapper_kind (mapper_kind_reg),
        .state       (state_reg),
        .mode        (mode),
        .address     (address),
        .write_data  (write_data),
        .state_next  (state_next),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mapper_kind_reg        <= KIND_NONE;
            state_reg.ram_enable   <= 1'b0;
            state_reg.rom_bank     <= RomBkW'(1);
            state_reg.ram_bank     <= '0;
            state_reg.banking_mode <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mapper_kind_reg <= cfg_wr_data;
            end
            if (accept) begin
                state_reg <= state_next;
            end
        end
    end

    cbm_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (buf_full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    assign target           = rsp_data.target;
    assign physical_address = rsp_data.physical_address;
    assign data_out         = rsp_data.data_out;

endmodule

`default_nettype wire
